>>> rtl/skvt_pkg.sv
// Shared types and codes for the sorted key/value table.
// Holds the word structs, command and status codes, and the cell control struct.
// No dependencies.
package skvt_pkg;

  localparam int KEY_W         = 32;
  localparam int DATUM_PORT_W  = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;

  // Command codes; codes six and seven are ignored
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STEP   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_EMPTY  = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_CURSOR = 2'd3;

  // What every cell does in the update cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [KEY_W-1:0]  key;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [KEY_W-1:0]   key;
    logic [DATUM_PORT_W-1:0]   datum;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic                      cursor_valid;
    logic signed [KEY_W-1:0]   sel_key;
    logic [DATUM_PORT_W-1:0]   sel_datum;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
  } out_word_t;

endpackage

>>> rtl/skvt_cell.sv
// One slot of the sorted table: a key and a datum register.
// Compares its key with the broadcast key and shifts with its neighbors.
// Depends on skvt_pkg.
module skvt_cell #(
  parameter int DATUM_WIDTH = 32
) (
  input  logic                            clk,
  input  skvt_pkg::cell_ctrl_t            ctrl,
  input  logic [DATUM_WIDTH-1:0]          datum_in,
  input  logic                            occ,
  input  logic                            prev_lt,
  input  logic signed [skvt_pkg::KEY_W-1:0] left_key,
  input  logic [DATUM_WIDTH-1:0]          left_data,
  input  logic signed [skvt_pkg::KEY_W-1:0] right_key,
  input  logic [DATUM_WIDTH-1:0]          right_data,
  output logic signed [skvt_pkg::KEY_W-1:0] key_out,
  output logic [DATUM_WIDTH-1:0]          data_out,
  output logic                            lt,
  output logic                            eq,
  output logic                            at_pos
);

  logic signed [skvt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [DATUM_WIDTH-1:0]            data_r, data_nxt;

  // Compare against the broadcast key; only occupied slots count
  assign lt     = occ && (key_r < ctrl.key);
  assign eq     = occ && (key_r == ctrl.key);
  assign at_pos = !lt && prev_lt;

  // Pick the next contents of this slot
  always_comb begin
    key_nxt  = key_r;
    data_nxt = data_r;
    unique case (ctrl.op)
      skvt_pkg::OP_WRITE: begin
        if (eq) begin
          data_nxt = datum_in;
        end
      end
      skvt_pkg::OP_INSERT: begin
        if (at_pos) begin
          key_nxt  = ctrl.key;
          data_nxt = datum_in;
        end else if (!lt) begin
          key_nxt  = left_key;
          data_nxt = left_data;
        end
      end
      skvt_pkg::OP_REMOVE: begin
        if (!lt) begin
          key_nxt  = right_key;
          data_nxt = right_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
  end

  assign key_out  = key_r;
  assign data_out = data_r;

endmodule

>>> rtl/sorted_key_value_table_top.sv
// Sorted key/value table with cursor: a row of CAPACITY slot cells.
// Flow: an accepted word passes the update state (cell update) and the load state
// (result load); a new word is taken only in the idle state, after the load. An untaken result
// word holds the load state and stalls the input.
// Reset: synchronous, active low; clears count, cursor and handshake state.
// Slot contents are not cleared; only slots below the count are ever read.
module sorted_key_value_table_top #(
  parameter int CAPACITY    = 16,
  parameter int DATUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  skvt_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output skvt_pkg::out_word_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [skvt_pkg::CMD_W-1:0]          cmd_r;
  logic signed [skvt_pkg::KEY_W-1:0]   key_r;
  logic [skvt_pkg::DATUM_PORT_W-1:0]   datum_r;

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [POS_W-1:0]              cur_pos_r, cur_pos_nxt;
  logic                          cur_pres_r, cur_pres_nxt;
  logic [skvt_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic                          out_valid_r;
  skvt_pkg::out_word_t           out_data_r;

  skvt_pkg::cell_ctrl_t          ctrl;
  logic [DATUM_WIDTH-1:0]        din;

  logic signed [skvt_pkg::KEY_W-1:0] cell_key  [CAPACITY];
  logic [DATUM_WIDTH-1:0]            cell_data [CAPACITY];
  logic [CAPACITY-1:0]               occ_vec, lt_vec, eq_vec, pos_vec;

  logic                  hit, full, can_load, in_fire;
  logic [POS_W-1:0]      pos;
  logic [CNT_W-1:0]      cur_ext;
  logic [DATUM_WIDTH-1:0] cur_data;
  logic [skvt_pkg::DATUM_PORT_W-1:0] cur_data_port;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;

  // Fit the datum word to the stored width
  generate
    if (DATUM_WIDTH >= skvt_pkg::DATUM_PORT_W) begin : g_din_wide
      assign din           = DATUM_WIDTH'(datum_r);
      assign cur_data_port = cur_data[skvt_pkg::DATUM_PORT_W-1:0];
    end else begin : g_din_narrow
      assign din           = datum_r[DATUM_WIDTH-1:0];
      assign cur_data_port = skvt_pkg::DATUM_PORT_W'(cur_data);
    end
  endgenerate

  // Row of slot cells
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                              prev_lt_w;
      logic signed [skvt_pkg::KEY_W-1:0] left_key_w, right_key_w;
      logic [DATUM_WIDTH-1:0]            left_data_w, right_data_w;

      assign occ_vec[i] = (CNT_W'(i) < count_r);

      if (i == 0) begin : g_first
        assign prev_lt_w   = 1'b1;
        assign left_key_w  = cell_key[i];
        assign left_data_w = cell_data[i];
      end else begin : g_mid
        assign prev_lt_w   = lt_vec[i-1];
        assign left_key_w  = cell_key[i-1];
        assign left_data_w = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_key_w  = cell_key[i];
        assign right_data_w = cell_data[i];
      end else begin : g_inner
        assign right_key_w  = cell_key[i+1];
        assign right_data_w = cell_data[i+1];
      end

      skvt_cell #(
        .DATUM_WIDTH (DATUM_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .datum_in   (din),
        .occ        (occ_vec[i]),
        .prev_lt    (prev_lt_w),
        .left_key   (left_key_w),
        .left_data  (left_data_w),
        .right_key  (right_key_w),
        .right_data (right_data_w),
        .key_out    (cell_key[i]),
        .data_out   (cell_data[i]),
        .lt         (lt_vec[i]),
        .eq         (eq_vec[i]),
        .at_pos     (pos_vec[i])
      );
    end
  endgenerate

  // Encode the one-hot position marker
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_vec[i]) begin
        pos = pos | POS_W'(i);
      end
    end
  end

  assign hit     = |eq_vec;
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign cur_ext = CNT_W'(cur_pos_r);

  // Decode the command into the cell operation and the new count and cursor
  always_comb begin
    ctrl.op      = skvt_pkg::OP_HOLD;
    ctrl.key     = key_r;
    status_nxt   = skvt_pkg::STATUS_OK;
    count_nxt    = count_r;
    cur_pos_nxt  = cur_pos_r;
    cur_pres_nxt = cur_pres_r;
    unique case (cmd_r)
      skvt_pkg::CMD_INSERT: begin
        cur_pres_nxt = 1'b0;
        if (hit) begin
          ctrl.op = skvt_pkg::OP_WRITE;
        end else if (full) begin
          status_nxt = skvt_pkg::STATUS_FULL;
        end else begin
          ctrl.op   = skvt_pkg::OP_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      skvt_pkg::CMD_REMOVE: begin
        if (!hit) begin
          status_nxt = skvt_pkg::STATUS_NOT_FOUND;
        end else begin
          ctrl.op   = skvt_pkg::OP_REMOVE;
          count_nxt = count_r - 1'b1;
          if (cur_pres_r) begin
            if (cur_pos_r == pos) begin
              cur_pres_nxt = 1'b0;
            end else if (cur_pos_r > pos) begin
              cur_pos_nxt = cur_pos_r - 1'b1;
            end
          end
        end
      end
      skvt_pkg::CMD_FIND: begin
        if (hit) begin
          cur_pos_nxt  = pos;
          cur_pres_nxt = 1'b1;
        end else begin
          cur_pres_nxt = 1'b0;
          status_nxt   = skvt_pkg::STATUS_NOT_FOUND;
        end
      end
      skvt_pkg::CMD_FIRST: begin
        if (count_r == '0) begin
          cur_pres_nxt = 1'b0;
          status_nxt   = skvt_pkg::STATUS_NO_CURSOR;
        end else begin
          cur_pos_nxt  = '0;
          cur_pres_nxt = 1'b1;
        end
      end
      skvt_pkg::CMD_STEP: begin
        if (!cur_pres_r) begin
          status_nxt = skvt_pkg::STATUS_NO_CURSOR;
        end else if (cur_ext + 1'b1 >= count_r) begin
          cur_pres_nxt = 1'b0;
        end else begin
          cur_pos_nxt = cur_pos_r + 1'b1;
        end
      end
      skvt_pkg::CMD_EMPTY: begin
        count_nxt    = '0;
        cur_pres_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    // Drop a cursor that falls past the last entry
    if (cur_pres_nxt && (CNT_W'(cur_pos_nxt) >= count_nxt)) begin
      cur_pres_nxt = 1'b0;
    end
    // Cells only move in the update cycle
    if (state_r != ST_EXEC) begin
      ctrl.op = skvt_pkg::OP_HOLD;
    end
  end

  // Sequence one word through capture, update and read
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_data.command;
      key_r   <= in_data.key;
      datum_r <= in_data.datum;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      cur_pos_r  <= '0;
      cur_pres_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC) begin
        count_r    <= count_nxt;
        cur_pos_r  <= cur_pos_nxt;
        cur_pres_r <= cur_pres_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      status_r <= status_nxt;
    end
  end

  assign cur_data = cell_data[cur_pos_r];

  // Output register: load the result word, hold it until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_LOAD && can_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && can_load) begin
      out_data_r.status       <= status_r;
      out_data_r.cursor_valid <= cur_pres_r;
      out_data_r.sel_key      <= cur_pres_r ? cell_key[cur_pos_r] : '0;
      out_data_r.sel_datum    <= cur_pres_r ? cur_data_port : '0;
      out_data_r.entry_count  <= skvt_pkg::ENTRY_COUNT_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_pres_r |-> (cur_ext < count_r))
    else $error("cursor points past the last entry");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted word did not enter the update cycle");

  a_no_cursor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.cursor_valid) |->
      (out_data_r.sel_key == '0 && out_data_r.sel_datum == '0))
    else $error("cursor fields not zero without a cursor");

endmodule
